>>> rtl/ubhe_pkg.sv
// Package for the serial bootloader host engine: phase encoding, request codes,
// status codes, protocol bytes and register indexes. No dependencies.
package ubhe_pkg;

    // Request types carried by req_type
    localparam logic [2:0] REQ_CONNECT  = 3'd0;
    localparam logic [2:0] REQ_ERASE    = 3'd1;
    localparam logic [2:0] REQ_FW_BYTE  = 3'd2;
    localparam logic [2:0] REQ_REPLY    = 3'd3;
    localparam logic [2:0] REQ_GO       = 3'd4;
    localparam logic [2:0] REQ_TX_SLOT  = 3'd5;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Status codes
    localparam logic [3:0] ST_CONNECTED      = 4'd0;
    localparam logic [3:0] ST_CONNECT_NACK   = 4'd1;
    localparam logic [3:0] ST_ERASED         = 4'd2;
    localparam logic [3:0] ST_ERASE_CMD_NACK = 4'd3;
    localparam logic [3:0] ST_ERASE_CNF_NACK = 4'd4;
    localparam logic [3:0] ST_BLOCK_WRITTEN  = 4'd5;
    localparam logic [3:0] ST_WR_CMD_NACK    = 4'd6;
    localparam logic [3:0] ST_WR_ADDR_NACK   = 4'd7;
    localparam logic [3:0] ST_WR_DATA_NACK   = 4'd8;
    localparam logic [3:0] ST_GO_OK          = 4'd9;
    localparam logic [3:0] ST_GO_CMD_NACK    = 4'd10;
    localparam logic [3:0] ST_GO_ADDR_NACK   = 4'd11;
    localparam logic [3:0] ST_BUSY           = 4'd12;

    // Protocol bytes
    localparam logic [7:0] BYTE_SYNC     = 8'h7F;
    localparam logic [7:0] BYTE_ACK      = 8'h79;
    localparam logic [7:0] BYTE_WR_CMD   = 8'h31;
    localparam logic [7:0] BYTE_WR_CPL   = 8'hCE;
    localparam logic [7:0] BYTE_ER_CMD   = 8'h43;
    localparam logic [7:0] BYTE_ER_CPL   = 8'hBC;
    localparam logic [7:0] BYTE_GO_CMD   = 8'h21;
    localparam logic [7:0] BYTE_GO_CPL   = 8'hDE;
    localparam logic [7:0] BYTE_ER_ALL   = 8'hFF;
    localparam logic [7:0] BYTE_ER_ALL_X = 8'h00;

    // Configuration registers
    localparam int unsigned   CFG_IDX_W        = 1;
    localparam logic [0:0]    REG_BASE_ADDRESS = 1'b0;
    localparam logic [0:0]    REG_BLOCK_SIZE   = 1'b1;
    localparam logic [31:0]   BASE_ADDR_RESET  = 32'h0800_0000;
    localparam logic [8:0]    BLOCK_SIZE_RESET = 9'd256;

    typedef enum logic [16:0] {
        PH_IDLE      = 17'b0_0000_0000_0000_0001,
        PH_CONN_TX   = 17'b0_0000_0000_0000_0010,
        PH_CONN_WAIT = 17'b0_0000_0000_0000_0100,
        PH_ER1_TX    = 17'b0_0000_0000_0000_1000,
        PH_ER1_WAIT  = 17'b0_0000_0000_0001_0000,
        PH_ER2_TX    = 17'b0_0000_0000_0010_0000,
        PH_ER2_WAIT  = 17'b0_0000_0000_0100_0000,
        PH_WH_TX     = 17'b0_0000_0000_1000_0000,
        PH_WH_WAIT   = 17'b0_0000_0001_0000_0000,
        PH_WA_TX     = 17'b0_0000_0010_0000_0000,
        PH_WA_WAIT   = 17'b0_0000_0100_0000_0000,
        PH_WD_TX     = 17'b0_0000_1000_0000_0000,
        PH_WD_WAIT   = 17'b0_0001_0000_0000_0000,
        PH_G1_TX     = 17'b0_0010_0000_0000_0000,
        PH_G1_WAIT   = 17'b0_0100_0000_0000_0000,
        PH_G2_TX     = 17'b0_1000_0000_0000_0000,
        PH_G2_WAIT   = 17'b1_0000_0000_0000_0000
    } phase_t;

endpackage

>>> rtl/ubhe_req_if.sv
// Request channel interface: valid/ready plus one request item.
// Depends on nothing.
interface ubhe_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output req_type, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input last_byte,
                    output ready);
endinterface

>>> rtl/ubhe_res_if.sv
// Result channel interface: valid/ready plus one result item.
// Depends on nothing.
interface ubhe_res_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic [3:0]  status_code;
    logic [31:0] block_address;

    modport source (output valid, output out_kind, output tx_byte, output status_code,
                    output block_address, input ready);
    modport sink   (input valid, input out_kind, input tx_byte, input status_code,
                    input block_address, output ready);
endinterface

>>> rtl/ubhe_cfg_if.sv
// Configuration write channel interface: valid/ready, register index, data.
// Depends on nothing.
interface ubhe_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  reg_index;
    logic [31:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> rtl/uart_bootloader_host_engine_unit.sv
// Top level of the serial bootloader host engine.
// Depends on ubhe_pkg, the three channel interfaces and ubhe_block_buf.
//
// Usage:
//   req  - request items: connect, erase all, firmware byte, device reply byte,
//          go, transmit slot. One item per cycle while req.ready is high.
//   res  - result items: a byte for the serial line or a status report.
//          At most one result per request item.
//   cfg  - register writes (base address, block size); always ready, to be
//          used only while the engine is idle.
// A result is registered and shows on res in the cycle after the request
// item that caused it is accepted. Throughput is one item per cycle while
// req.ready is high; the state update and result for an item are formed in
// the accepting cycle. Data bytes of a write block are prefetched from the
// block buffer by the next slot index, so its registered read adds no wait.
// Stall: req.ready drops only while a result is held unread in the output
// register and res.ready is low; it returns in the cycle res is taken.
// Reset: phase idle, buffer empty, registers at reset values, no result
// pending. The buffer itself is not cleared; only bytes of the current fill
// are ever sent.
module uart_bootloader_host_engine_unit #(
    parameter int unsigned BLOCK_BYTES = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    ubhe_req_if.sink  req,
    ubhe_res_if.source res,
    ubhe_cfg_if.sink  cfg
);

    import ubhe_pkg::*;

    localparam int unsigned AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int unsigned CW = $clog2(BLOCK_BYTES + 1);
    localparam int unsigned SW = (CW > 3) ? CW : 3;

    // State
    phase_t          phase_reg, phase_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [31:0]     waddr_reg, waddr_next;
    logic [SW-1:0]   sidx_reg, sidx_next;
    logic [7:0]      xor_reg, xor_next;
    logic [31:0]     base_reg;
    logic [8:0]      bsize_reg;

    // Output register
    logic            ovalid_reg;
    logic            okind_reg;
    logic [7:0]      otx_reg;
    logic [3:0]      ost_reg;
    logic [31:0]     oaddr_reg;

    logic            r_valid;
    logic            r_kind;
    logic [7:0]      r_tx;
    logic [3:0]      r_st;
    logic [31:0]     r_addr;

    logic            accept;
    logic            ack;
    logic [8:0]      eff_block;
    logic [7:0]      tb;
    logic            buf_wr_en;
    logic [AW-1:0]   buf_rd_addr;
    logic [7:0]      buf_rd_data;
    logic [SW-1:0]   sidx_m1;

    assign req.ready = !ovalid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign ack       = (req.data_byte == BYTE_ACK);

    always_comb
    begin
        if (bsize_reg == 9'd0)
        begin
            eff_block = 9'd1;
        end
        else if (bsize_reg > 9'(BLOCK_BYTES))
        begin
            eff_block = 9'(BLOCK_BYTES);
        end
        else
        begin
            eff_block = bsize_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        waddr_next = waddr_reg;
        sidx_next  = sidx_reg;
        xor_next   = xor_reg;
        r_valid    = 1'b0;
        r_kind     = KIND_TX;
        r_tx       = 8'h00;
        r_st       = ST_CONNECTED;
        r_addr     = 32'h0;
        buf_wr_en  = 1'b0;
        tb         = 8'h00;

        if (accept)
        begin
            unique case (req.req_type) inside
                REQ_CONNECT, REQ_ERASE, REQ_FW_BYTE, REQ_GO:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        r_valid = 1'b1;
                        r_kind  = KIND_STATUS;
                        r_st    = ST_BUSY;
                    end
                    else
                    begin
                        unique case (req.req_type)
                            REQ_CONNECT:
                            begin
                                waddr_next = base_reg;
                                fill_next  = '0;
                                phase_next = PH_CONN_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                            end
                            REQ_ERASE:
                            begin
                                phase_next = PH_ER1_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                            end
                            REQ_GO:
                            begin
                                phase_next = PH_G1_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                            end
                            default:
                            begin
                                // firmware byte
                                if (fill_reg < CW'(BLOCK_BYTES))
                                begin
                                    buf_wr_en = 1'b1;
                                    fill_next = fill_reg + CW'(1);
                                end
                                if ((9'(fill_next) >= eff_block) || req.last_byte)
                                begin
                                    phase_next = PH_WH_TX;
                                    sidx_next  = '0;
                                    xor_next   = 8'h00;
                                end
                            end
                        endcase
                    end
                end

                REQ_REPLY:
                begin
                    unique case (phase_reg)
                        PH_CONN_WAIT:
                        begin
                            phase_next = PH_IDLE;
                            r_valid    = 1'b1;
                            r_kind     = KIND_STATUS;
                            r_st       = ack ? ST_CONNECTED : ST_CONNECT_NACK;
                        end
                        PH_ER1_WAIT:
                        begin
                            if (ack)
                            begin
                                phase_next = PH_ER2_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                r_valid    = 1'b1;
                                r_kind     = KIND_STATUS;
                                r_st       = ST_ERASE_CMD_NACK;
                            end
                        end
                        PH_ER2_WAIT:
                        begin
                            phase_next = PH_IDLE;
                            r_valid    = 1'b1;
                            r_kind     = KIND_STATUS;
                            r_st       = ack ? ST_ERASED : ST_ERASE_CNF_NACK;
                        end
                        PH_WH_WAIT, PH_WA_WAIT:
                        begin
                            sidx_next = '0;
                            xor_next  = 8'h00;
                            if (ack)
                            begin
                                phase_next = (phase_reg == PH_WH_WAIT) ? PH_WA_TX : PH_WD_TX;
                            end
                            else
                            begin
                                // refused: restart the whole block
                                phase_next = PH_WH_TX;
                                r_valid    = 1'b1;
                                r_kind     = KIND_STATUS;
                                r_st       = (phase_reg == PH_WH_WAIT) ? ST_WR_CMD_NACK
                                                                       : ST_WR_ADDR_NACK;
                                r_addr     = waddr_reg;
                            end
                        end
                        PH_WD_WAIT:
                        begin
                            r_valid = 1'b1;
                            r_kind  = KIND_STATUS;
                            r_addr  = waddr_reg;
                            if (ack)
                            begin
                                waddr_next = waddr_reg + 32'(fill_reg);
                                fill_next  = '0;
                                phase_next = PH_IDLE;
                                r_st       = ST_BLOCK_WRITTEN;
                            end
                            else
                            begin
                                phase_next = PH_WH_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                                r_st       = ST_WR_DATA_NACK;
                            end
                        end
                        PH_G1_WAIT:
                        begin
                            if (ack)
                            begin
                                phase_next = PH_G2_TX;
                                sidx_next  = '0;
                                xor_next   = 8'h00;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                r_valid    = 1'b1;
                                r_kind     = KIND_STATUS;
                                r_st       = ST_GO_CMD_NACK;
                            end
                        end
                        PH_G2_WAIT:
                        begin
                            phase_next = PH_IDLE;
                            r_valid    = 1'b1;
                            r_kind     = KIND_STATUS;
                            r_st       = ack ? ST_GO_OK : ST_GO_ADDR_NACK;
                        end
                        default:
                        begin
                            // stray reply: ignored
                        end
                    endcase
                end

                REQ_TX_SLOT:
                begin
                    unique case (phase_reg)
                        PH_CONN_TX:
                        begin
                            phase_next = PH_CONN_WAIT;
                            r_valid    = 1'b1;
                            r_tx       = BYTE_SYNC;
                        end
                        PH_ER1_TX, PH_ER2_TX, PH_WH_TX, PH_G1_TX:
                        begin
                            r_valid   = 1'b1;
                            sidx_next = sidx_reg + SW'(1);
                            unique case (phase_reg)
                                PH_ER1_TX:
                                begin
                                    r_tx = (sidx_reg == '0) ? BYTE_ER_CMD : BYTE_ER_CPL;
                                    if (sidx_next >= SW'(2)) phase_next = PH_ER1_WAIT;
                                end
                                PH_ER2_TX:
                                begin
                                    r_tx = (sidx_reg == '0) ? BYTE_ER_ALL : BYTE_ER_ALL_X;
                                    if (sidx_next >= SW'(2)) phase_next = PH_ER2_WAIT;
                                end
                                PH_WH_TX:
                                begin
                                    r_tx = (sidx_reg == '0) ? BYTE_WR_CMD : BYTE_WR_CPL;
                                    if (sidx_next >= SW'(2)) phase_next = PH_WH_WAIT;
                                end
                                default:
                                begin
                                    r_tx = (sidx_reg == '0) ? BYTE_GO_CMD : BYTE_GO_CPL;
                                    if (sidx_next >= SW'(2)) phase_next = PH_G1_WAIT;
                                end
                            endcase
                        end
                        PH_WA_TX, PH_G2_TX:
                        begin
                            r_valid = 1'b1;
                            if (sidx_reg < SW'(4))
                            begin
                                // address bytes, most significant first
                                case (sidx_reg[1:0])
                                    2'd0:    tb = (phase_reg == PH_WA_TX) ? waddr_reg[31:24]
                                                                          : base_reg[31:24];
                                    2'd1:    tb = (phase_reg == PH_WA_TX) ? waddr_reg[23:16]
                                                                          : base_reg[23:16];
                                    2'd2:    tb = (phase_reg == PH_WA_TX) ? waddr_reg[15:8]
                                                                          : base_reg[15:8];
                                    default: tb = (phase_reg == PH_WA_TX) ? waddr_reg[7:0]
                                                                          : base_reg[7:0];
                                endcase
                                r_tx      = tb;
                                xor_next  = xor_reg ^ tb;
                                sidx_next = sidx_reg + SW'(1);
                            end
                            else
                            begin
                                r_tx       = xor_reg;
                                phase_next = (phase_reg == PH_WA_TX) ? PH_WA_WAIT : PH_G2_WAIT;
                            end
                        end
                        PH_WD_TX:
                        begin
                            r_valid = 1'b1;
                            if (sidx_reg == '0)
                            begin
                                tb        = 8'(fill_reg - CW'(1));
                                r_tx      = tb;
                                xor_next  = xor_reg ^ tb;
                                sidx_next = sidx_reg + SW'(1);
                            end
                            else if (sidx_reg <= SW'(fill_reg))
                            begin
                                tb        = buf_rd_data;
                                r_tx      = tb;
                                xor_next  = xor_reg ^ tb;
                                sidx_next = sidx_reg + SW'(1);
                            end
                            else
                            begin
                                r_tx       = xor_reg;
                                phase_next = PH_WD_WAIT;
                            end
                        end
                        default:
                        begin
                            // nothing queued
                        end
                    endcase
                end

                default:
                begin
                    // unused request codes
                end
            endcase
        end

        // a base address write moves the write address only when idle and empty
        if (cfg.valid && (cfg.reg_index == REG_BASE_ADDRESS) && (phase_reg == PH_IDLE)
            && (fill_reg == '0))
        begin
            waddr_next = cfg.wr_data;
        end
    end

    // Prefetch the entry the next data slot will need
    assign sidx_m1     = sidx_next - SW'(1);
    assign buf_rd_addr = sidx_m1[AW-1:0];

    ubhe_block_buf #(
        .DEPTH (BLOCK_BYTES),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (req.data_byte),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            fill_reg  <= '0;
            waddr_reg <= BASE_ADDR_RESET;
            sidx_reg  <= '0;
            xor_reg   <= 8'h00;
            base_reg  <= BASE_ADDR_RESET;
            bsize_reg <= BLOCK_SIZE_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            waddr_reg <= waddr_next;
            sidx_reg  <= sidx_next;
            xor_reg   <= xor_next;
            if (cfg.valid)
            begin
                unique case (cfg.reg_index)
                    REG_BASE_ADDRESS:
                    begin
                        base_reg <= cfg.wr_data;
                    end
                    default:
                    begin
                        bsize_reg <= cfg.wr_data[8:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (r_valid)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_valid)
        begin
            okind_reg <= r_kind;
            otx_reg   <= r_tx;
            ost_reg   <= r_st;
            oaddr_reg <= r_addr;
        end
    end

    assign res.valid         = ovalid_reg;
    assign res.out_kind      = okind_reg;
    assign res.tx_byte       = otx_reg;
    assign res.status_code   = ost_reg;
    assign res.block_address = oaddr_reg;

endmodule

>>> rtl/ubhe_block_buf.sv
// Firmware block buffer: one write port, one read port with registered data.
// Depends on nothing.
module ubhe_block_buf #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
